// ----- src/pending_exit_signal_set_top_macros.svh -----
// Assertion macros shared by the pending exit signal set RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PENDING_EXIT_SIGNAL_SET_TOP_MACROS_SVH
`define PENDING_EXIT_SIGNAL_SET_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PESS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pess assertion failed");

// next-cycle implication, disabled while in reset
`define PESS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pess assertion failed");

`endif

// ----- src/pess_pkg.sv -----
// Types and constants of the pending exit signal set.
// Depends on nothing; imported by pess_core and pending_exit_signal_set_top.
`default_nettype none

package pess_pkg;

    localparam int EP_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_LOAD,
        S_DONE
    } t_state;

    typedef enum logic {
        ACT_NOTIFY = 1'b0,
        ACT_QUERY  = 1'b1
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic signed [EP_W-1:0]   endpoint;
        logic signed [EP_W-1:0]   ipc_endpoint;
    } t_cmd;

    typedef struct packed {
        logic                     status;
        logic                     found;
        logic signed [EP_W-1:0]   returned_endpoint;
        logic                     more_pending;
        logic                     notify_ipc;
    } t_result;

endpackage

`default_nettype wire

// ----- src/pess_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none

module pess_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/pess_core.sv -----
// Slot table sequencer: occupancy bits, endpoint RAM and one shared compare unit.
// Depends on pess_pkg, pess_ram and the assertion macro header.
`default_nettype none
`include "pending_exit_signal_set_top_macros.svh"

module pess_core #(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire pess_pkg::t_cmd  i_cmd,
    output logic                 o_idle,
    output logic                 o_res_valid,
    input  wire logic            i_res_ack,
    output pess_pkg::t_result    o_res
);

    import pess_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] SlotNum = CW'(SLOT_COUNT);
    localparam logic [IW-1:0] LastIdx = IW'(SLOT_COUNT - 1);

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    t_result                 r_res;
    logic [SLOT_COUNT-1:0]   r_used;
    logic [CW-1:0]           r_idx;
    logic                    r_cmp_vld;
    logic [IW-1:0]           r_cmp_idx;
    logic                    r_found;
    logic [IW-1:0]           r_first_idx;
    logic                    r_more;
    logic                    r_present;

    logic                    w_issue;
    logic                    w_we;
    logic [IW-1:0]           w_addr;
    logic [EP_W-1:0]         w_rdata;
    logic                    w_cmp_used;
    logic                    w_match;
    logic                    w_dup;
    logic                    w_scan_end;
    logic                    w_is_query;

    // endpoint table
    pess_ram #(
        .WIDTH (EP_W),
        .DEPTH (SLOT_COUNT)
    ) u_ep_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_cmd.endpoint),
        .o_rdata (w_rdata)
    );

    // shared compare stage, one slot per cycle
    assign w_is_query = (r_cmd.action == ACT_QUERY);
    assign w_cmp_used = r_used[r_cmp_idx];
    assign w_match    = w_is_query ? w_cmp_used : !w_cmp_used;
    assign w_dup      = !w_is_query && w_cmp_used && (w_rdata == r_cmd.endpoint);
    assign w_scan_end = r_cmp_vld && (r_cmp_idx == LastIdx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (w_scan_end) n_state = S_COMMIT;
            S_COMMIT: n_state = S_LOAD;
            S_LOAD:   n_state = S_DONE;
            S_DONE:   if (i_res_ack) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        w_issue     = 1'b0;
        w_we        = 1'b0;
        w_addr      = r_first_idx;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
            end
            S_SCAN: begin
                w_issue = (r_idx < SlotNum);
                w_addr  = r_idx[IW-1:0];
            end
            S_COMMIT: begin
                // insert into the lowest free slot unless already present
                w_we = !w_is_query && !r_present && r_found;
            end
            S_LOAD: begin
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // occupancy bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= w_issue;
            if (w_we) begin
                r_used[r_first_idx] <= 1'b1;
            end
            if (r_state == S_COMMIT && w_is_query && r_found) begin
                r_used[r_first_idx] <= 1'b0;
            end
        end
    end

    // scan datapath and result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd     <= i_cmd;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_more    <= 1'b0;
            r_present <= 1'b0;
        end
        if (w_issue) begin
            r_idx <= r_idx + CW'(1);
        end
        r_cmp_idx <= r_idx[IW-1:0];
        if (r_state == S_SCAN && r_cmp_vld) begin
            if (w_match && !r_found) begin
                r_found     <= 1'b1;
                r_first_idx <= r_cmp_idx;
            end
            if (w_is_query && w_cmp_used && r_found) begin
                r_more <= 1'b1;
            end
            if (w_dup) begin
                r_present <= 1'b1;
            end
        end
        if (r_state == S_LOAD) begin
            if (w_is_query) begin
                r_res.status            <= 1'b0;
                r_res.notify_ipc        <= 1'b0;
                r_res.found             <= r_found;
                r_res.returned_endpoint <= r_found ? w_rdata : '0;
                r_res.more_pending      <= r_more;
            end else begin
                r_res.status            <= !r_present && !r_found;
                r_res.notify_ipc        <= (r_present || r_found)
                                           && (r_cmd.ipc_endpoint != '0)
                                           && (r_cmd.ipc_endpoint != r_cmd.endpoint);
                r_res.found             <= 1'b0;
                r_res.returned_endpoint <= '0;
                r_res.more_pending      <= 1'b0;
            end
        end
    end

    assign o_res = r_res;

    // checks
    `PESS_ASSERT_NEXT(a_insert_sets_used, i_clk, i_rst_n, w_we,
        r_used[$past(w_addr)])
    `PESS_ASSERT_NEXT(a_query_frees_slot, i_clk, i_rst_n,
        (r_state == S_COMMIT) && w_is_query && r_found, !r_used[$past(r_first_idx)])
    `PESS_ASSERT_IMP(a_full_only_when_full, i_clk, i_rst_n,
        o_res_valid && o_res.status, &r_used)
    `PESS_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= SlotNum)
    `PESS_ASSERT_IMP(a_query_no_notify_fields, i_clk, i_rst_n,
        o_res_valid && w_is_query, !o_res.status && !o_res.notify_ipc)

endmodule

`default_nettype wire

// ----- src/pending_exit_signal_set_top.sv -----
// Pending exit signal set: a table of SLOT_COUNT endpoint slots. A notify
// transfer inserts its endpoint into the lowest free slot unless already held
// and says whether the ipc server should be told; a query transfer removes the
// endpoint in the lowest held slot and returns it. One item is worked on at a
// time, from its input transfer until its result is handed on: the sequencer
// walks every slot once, reading one endpoint a cycle from the single-port
// table RAM into one shared comparator, then commits, loads the result and
// hands it to the output register. A result may wait in the output register
// while the next item is already being taken in.
// Depends on pess_pkg and pess_core.
`default_nettype none

module pending_exit_signal_set_top #(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_action,
    input  wire logic signed [pess_pkg::EP_W-1:0] i_endpoint,
    input  wire logic signed [pess_pkg::EP_W-1:0] i_ipc_endpoint,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_status,
    output logic                                 o_found,
    output logic signed [pess_pkg::EP_W-1:0]     o_returned_endpoint,
    output logic                                 o_more_pending,
    output logic                                 o_notify_ipc
);

    import pess_pkg::*;

    t_cmd     w_cmd;
    t_result  w_res;
    t_result  r_out;
    logic     r_out_valid;
    logic     w_idle;
    logic     w_res_valid;
    logic     w_res_ack;
    logic     w_start;

    // input transfer starts the sequencer
    assign o_in_ready          = w_idle;
    assign w_start             = i_in_valid && w_idle;
    assign w_cmd.action        = t_action'(i_action);
    assign w_cmd.endpoint      = i_endpoint;
    assign w_cmd.ipc_endpoint  = i_ipc_endpoint;

    pess_core #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_cmd       (w_cmd),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ack   (w_res_ack),
        .o_res       (w_res)
    );

    // output register, loads when empty or being drained
    assign w_res_ack = w_res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ack) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out.status;
    assign o_found             = r_out.found;
    assign o_returned_endpoint = r_out.returned_endpoint;
    assign o_more_pending      = r_out.more_pending;
    assign o_notify_ipc        = r_out.notify_ipc;

endmodule

`default_nettype wire
